FILE: rtl/vab_pkg.sv
package vab_pkg;

    localparam int VOXEL_W   = 8;
    localparam int SIZE_W    = 9;
    localparam int ORIGIN_W  = 16;
    localparam int BOUND_W   = 17;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } cfg_index_t;

    // Handed from the tracker to the result register on every voxel transfer.
    typedef struct packed {
        logic fire;
        logic found;
    } vab_ctrl_t;

endpackage

FILE: rtl/vab_tracker.sv
module vab_tracker #(
    parameter int MAX_DIM = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vab_pkg::SIZE_W-1:0]    size_x,
    input  logic [vab_pkg::SIZE_W-1:0]    size_y,
    input  logic [vab_pkg::SIZE_W-1:0]    size_z,
    input  logic                          accept,
    input  logic [vab_pkg::VOXEL_W-1:0]   voxel,
    output logic                          last_voxel,
    output vab_pkg::vab_ctrl_t            ctrl,
    output logic [$clog2(MAX_DIM)-1:0]    low_x,
    output logic [$clog2(MAX_DIM)-1:0]    low_y,
    output logic [$clog2(MAX_DIM)-1:0]    low_z,
    output logic [$clog2(MAX_DIM)-1:0]    high_x,
    output logic [$clog2(MAX_DIM)-1:0]    high_y,
    output logic [$clog2(MAX_DIM)-1:0]    high_z
);
    import vab_pkg::*;

    localparam int PW = $clog2(MAX_DIM);

    logic [PW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [PW-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic          seen_reg, seen_next;
    logic [PW-1:0] low_x_reg, low_y_reg, low_z_reg;
    logic [PW-1:0] high_x_reg, high_y_reg, high_z_reg;
    logic [PW-1:0] low_x_next, low_y_next, low_z_next;
    logic [PW-1:0] high_x_next, high_y_next, high_z_next;

    logic [PW-1:0] last_x, last_y, last_z;
    logic [PW-1:0] cur_x, cur_y, cur_z;
    logic          end_x, end_y, end_z;
    logic          hit;

    // A size of zero counts as one and a size above MAX_DIM as MAX_DIM.
    function automatic logic [PW-1:0] last_of(input logic [SIZE_W-1:0] s);
        int unsigned v;
        v = 32'(s);
        if (v == 0)
            return '0;
        else if (v > MAX_DIM)
            return PW'(MAX_DIM - 1);
        else
            return PW'(v - 1);
    endfunction

    assign last_x = last_of(size_x);
    assign last_y = last_of(size_y);
    assign last_z = last_of(size_z);

    // A counter left beyond a shrunken size is taken as sitting on the last position.
    assign end_x = pos_x_reg >= last_x;
    assign end_y = pos_y_reg >= last_y;
    assign end_z = pos_z_reg >= last_z;
    assign cur_x = end_x ? last_x : pos_x_reg;
    assign cur_y = end_y ? last_y : pos_y_reg;
    assign cur_z = end_z ? last_z : pos_z_reg;

    assign last_voxel = end_x && end_y && end_z;
    assign hit        = voxel != '0;

    always_comb
    begin
        low_x_next  = low_x_reg;
        low_y_next  = low_y_reg;
        low_z_next  = low_z_reg;
        high_x_next = high_x_reg;
        high_y_next = high_y_reg;
        high_z_next = high_z_reg;
        seen_next   = seen_reg;
        if (hit)
        begin
            seen_next = 1'b1;
            if (!seen_reg)
            begin
                low_x_next  = cur_x;
                low_y_next  = cur_y;
                low_z_next  = cur_z;
                high_x_next = cur_x;
                high_y_next = cur_y;
                high_z_next = cur_z;
            end
            else
            begin
                if (cur_x < low_x_reg)  low_x_next  = cur_x;
                if (cur_y < low_y_reg)  low_y_next  = cur_y;
                if (cur_z < low_z_reg)  low_z_next  = cur_z;
                if (cur_x > high_x_reg) high_x_next = cur_x;
                if (cur_y > high_y_reg) high_y_next = cur_y;
                if (cur_z > high_z_reg) high_z_next = cur_z;
            end
        end
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (!end_x)
        begin
            pos_x_next = cur_x + 1'b1;
        end
        else
        begin
            pos_x_next = '0;
            if (!end_y)
            begin
                pos_y_next = cur_y + 1'b1;
            end
            else
            begin
                pos_y_next = '0;
                pos_z_next = cur_z + 1'b1;
            end
        end
    end

    assign ctrl.fire  = accept && last_voxel;
    assign ctrl.found = seen_next;
    assign low_x  = low_x_next;
    assign low_y  = low_y_next;
    assign low_z  = low_z_next;
    assign high_x = high_x_next;
    assign high_y = high_y_next;
    assign high_z = high_z_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            seen_reg   <= 1'b0;
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            low_z_reg  <= '0;
            high_x_reg <= '0;
            high_y_reg <= '0;
            high_z_reg <= '0;
        end
        else if (accept)
        begin
            if (last_voxel)
            begin
                // The volume is complete, so everything clears for the next one.
                pos_x_reg  <= '0;
                pos_y_reg  <= '0;
                pos_z_reg  <= '0;
                seen_reg   <= 1'b0;
                low_x_reg  <= '0;
                low_y_reg  <= '0;
                low_z_reg  <= '0;
                high_x_reg <= '0;
                high_y_reg <= '0;
                high_z_reg <= '0;
            end
            else
            begin
                pos_x_reg  <= pos_x_next;
                pos_y_reg  <= pos_y_next;
                pos_z_reg  <= pos_z_next;
                seen_reg   <= seen_next;
                low_x_reg  <= low_x_next;
                low_y_reg  <= low_y_next;
                low_z_reg  <= low_z_next;
                high_x_reg <= high_x_next;
                high_y_reg <= high_y_next;
                high_z_reg <= high_z_next;
            end
        end
    end

endmodule

FILE: rtl/vab_result.sv
module vab_result #(
    parameter int MAX_DIM = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vab_pkg::vab_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_DIM)-1:0]          low_x,
    input  logic [$clog2(MAX_DIM)-1:0]          low_y,
    input  logic [$clog2(MAX_DIM)-1:0]          low_z,
    input  logic [$clog2(MAX_DIM)-1:0]          high_x,
    input  logic [$clog2(MAX_DIM)-1:0]          high_y,
    input  logic [$clog2(MAX_DIM)-1:0]          high_z,
    input  logic signed [vab_pkg::ORIGIN_W-1:0] origin_x,
    input  logic signed [vab_pkg::ORIGIN_W-1:0] origin_y,
    input  logic signed [vab_pkg::ORIGIN_W-1:0] origin_z,
    input  logic                                result_stall,
    output logic                                result_valid,
    output logic                                found,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_x,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_y,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_z,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_x,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_y,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_z
);
    import vab_pkg::*;

    localparam int PW = $clog2(MAX_DIM);

    logic                       valid_reg, valid_next;
    logic                       found_reg;
    logic signed [BOUND_W-1:0]  min_x_reg, min_y_reg, min_z_reg;
    logic signed [BOUND_W-1:0]  max_x_reg, max_y_reg, max_z_reg;

    // Origin plus offset, wrapped to the width of a bound; zero when nothing was found.
    function automatic logic [BOUND_W-1:0] bound(input logic [ORIGIN_W-1:0] org,
                                                 input logic [PW-1:0] off,
                                                 input logic hit);
        logic [BOUND_W-1:0] sum;
        sum = {org[ORIGIN_W-1], org} + {{(BOUND_W-PW){1'b0}}, off};
        return hit ? sum : '0;
    endfunction

    // The tracker only fires when this register is free or being emptied.
    assign valid_next = ctrl.fire || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            found_reg <= ctrl.found;
            min_x_reg <= bound(origin_x, low_x, ctrl.found);
            min_y_reg <= bound(origin_y, low_y, ctrl.found);
            min_z_reg <= bound(origin_z, low_z, ctrl.found);
            max_x_reg <= bound(origin_x, high_x, ctrl.found);
            max_y_reg <= bound(origin_y, high_y, ctrl.found);
            max_z_reg <= bound(origin_z, high_z, ctrl.found);
        end
    end

    assign result_valid = valid_reg;
    assign found        = found_reg;
    assign min_x        = min_x_reg;
    assign min_y        = min_y_reg;
    assign min_z        = min_z_reg;
    assign max_x        = max_x_reg;
    assign max_y        = max_y_reg;
    assign max_z        = max_z_reg;

endmodule

FILE: rtl/voxel_active_bounds.sv
// Occupied-voxel bounding box over a raster-ordered volume stream.
// Throughput: one voxel per cycle; only the final voxel of a volume waits while the
// result register still holds an untaken result.
// The result is registered and appears in the cycle after the transfer of the final voxel.
// Reset: sizes return to one, origins to zero, position counters and trackers clear.
module voxel_active_bounds #(
    parameter int MAX_DIM = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vab_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vab_pkg::ORIGIN_W-1:0]        cfg_data,
    input  logic                                voxel_valid,
    output logic                                voxel_stall,
    input  logic [vab_pkg::VOXEL_W-1:0]         voxel,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                found,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_x,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_y,
    output logic signed [vab_pkg::BOUND_W-1:0]  min_z,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_x,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_y,
    output logic signed [vab_pkg::BOUND_W-1:0]  max_z
);
    import vab_pkg::*;

    localparam int PW = $clog2(MAX_DIM);

    logic [SIZE_W-1:0]          size_x_reg, size_y_reg, size_z_reg;
    logic signed [ORIGIN_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic                       accept;
    logic                       last_voxel;
    vab_ctrl_t                  ctrl;
    logic [PW-1:0]              low_x, low_y, low_z, high_x, high_y, high_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg   <= SIZE_W'(1);
            size_y_reg   <= SIZE_W'(1);
            size_z_reg   <= SIZE_W'(1);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:   size_x_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:   size_y_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:   size_z_reg   <= cfg_data[SIZE_W-1:0];
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Only the final voxel of a volume needs room in the result register.
    assign voxel_stall = last_voxel && result_valid && result_stall;
    assign accept      = voxel_valid && !voxel_stall;

    vab_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .size_x     (size_x_reg),
        .size_y     (size_y_reg),
        .size_z     (size_z_reg),
        .accept     (accept),
        .voxel      (voxel),
        .last_voxel (last_voxel),
        .ctrl       (ctrl),
        .low_x      (low_x),
        .low_y      (low_y),
        .low_z      (low_z),
        .high_x     (high_x),
        .high_y     (high_y),
        .high_z     (high_z)
    );

    vab_result #(
        .MAX_DIM (MAX_DIM)
    ) u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .low_x        (low_x),
        .low_y        (low_y),
        .low_z        (low_z),
        .high_x       (high_x),
        .high_y       (high_y),
        .high_z       (high_z),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .origin_z     (origin_z_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .found        (found),
        .min_x        (min_x),
        .min_y        (min_y),
        .min_z        (min_z),
        .max_x        (max_x),
        .max_y        (max_y),
        .max_z        (max_z)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vab_pkg::*;

    localparam int MAX_DIM         = 256;
    localparam int POS_W           = $clog2(MAX_DIM);
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 300;
    localparam int TAIL_ITEMS      = 100;
    localparam int REPORT_LIMIT    = 10;

    // Indexes beyond the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {
        FILL_EMPTY,
        FILL_SPARSE,
        FILL_DENSE
    } fill_t;

    typedef struct packed {
        logic               found;
        logic [BOUND_W-1:0] min_x;
        logic [BOUND_W-1:0] min_y;
        logic [BOUND_W-1:0] min_z;
        logic [BOUND_W-1:0] max_x;
        logic [BOUND_W-1:0] max_y;
        logic [BOUND_W-1:0] max_z;
    } box_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ORIGIN_W-1:0]  cfg_data;
    logic                 voxel_valid;
    logic                 voxel_stall;
    logic [VOXEL_W-1:0]   voxel;
    logic                 result_valid;
    logic                 result_stall;
    logic                 found;
    logic [BOUND_W-1:0]   min_x;
    logic [BOUND_W-1:0]   min_y;
    logic [BOUND_W-1:0]   min_z;
    logic [BOUND_W-1:0]   max_x;
    logic [BOUND_W-1:0]   max_y;
    logic [BOUND_W-1:0]   max_z;

    // Predictor state: registers, position counters and occupancy trackers.
    logic [SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [ORIGIN_W-1:0] org_x, org_y, org_z;
    logic [POS_W-1:0]    at_x, at_y, at_z;
    logic                occupied;
    logic [POS_W-1:0]    lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

    box_t pending_boxes[$];

    int voxel_count;
    int volume_count;
    int occupied_volumes;
    int reg_writes;
    int results_seen;
    int failures;
    int hold_request;
    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_used;

    voxel_active_bounds #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .voxel_valid  (voxel_valid),
        .voxel_stall  (voxel_stall),
        .voxel        (voxel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .min_x        (min_x),
        .min_y        (min_y),
        .min_z        (min_z),
        .max_x        (max_x),
        .max_y        (max_y),
        .max_z        (max_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // A size of zero behaves as one and anything above MAX_DIM as MAX_DIM.
    function automatic logic [POS_W-1:0] last_pos(input logic [SIZE_W-1:0] s);
        if (s == '0)
            return '0;
        if (s > MAX_DIM)
            return POS_W'(MAX_DIM - 1);
        return POS_W'(s - 1'b1);
    endfunction

    function automatic logic [BOUND_W-1:0] to_bound(input logic [ORIGIN_W-1:0] org,
                                                  input logic [POS_W-1:0] off);
        return {org[ORIGIN_W-1], org} + BOUND_W'(off);
    endfunction

    function automatic int volume_len();
        return (int'(last_pos(size_x_reg)) + 1) * (int'(last_pos(size_y_reg)) + 1)
             * (int'(last_pos(size_z_reg)) + 1);
    endfunction

    function automatic void clear_volume();
        at_x = '0;
        at_y = '0;
        at_z = '0;
        occupied = 1'b0;
        lo_x = '0;
        lo_y = '0;
        lo_z = '0;
        hi_x = '0;
        hi_y = '0;
        hi_z = '0;
    endfunction

    // Advances the predicted volume by one voxel and queues the bounding box
    // when that voxel closes the volume.
    function automatic void track_voxel(input logic [VOXEL_W-1:0] v);
        logic [POS_W-1:0] lx, ly, lz, cx, cy, cz;
        logic             ex, ey, ez;
        box_t             box;
        lx = last_pos(size_x_reg);
        ly = last_pos(size_y_reg);
        lz = last_pos(size_z_reg);
        ex = at_x >= lx;
        ey = at_y >= ly;
        ez = at_z >= lz;
        // A counter left beyond a shrunken size counts as sitting on the last position.
        cx = ex ? lx : at_x;
        cy = ey ? ly : at_y;
        cz = ez ? lz : at_z;
        voxel_count++;
        if (v != '0)
        begin
            if (!occupied)
            begin
                lo_x = cx;
                lo_y = cy;
                lo_z = cz;
                hi_x = cx;
                hi_y = cy;
                hi_z = cz;
                occupied = 1'b1;
            end
            else
            begin
                if (cx < lo_x) lo_x = cx;
                if (cy < lo_y) lo_y = cy;
                if (cz < lo_z) lo_z = cz;
                if (cx > hi_x) hi_x = cx;
                if (cy > hi_y) hi_y = cy;
                if (cz > hi_z) hi_z = cz;
            end
        end
        if (ex && ey && ez)
        begin
            box = '0;
            if (occupied)
            begin
                box.found = 1'b1;
                box.min_x = to_bound(org_x, lo_x);
                box.min_y = to_bound(org_y, lo_y);
                box.min_z = to_bound(org_z, lo_z);
                box.max_x = to_bound(org_x, hi_x);
                box.max_y = to_bound(org_y, hi_y);
                box.max_z = to_bound(org_z, hi_z);
                occupied_volumes++;
            end
            pending_boxes.push_back(box);
            volume_count++;
            clear_volume();
        end
        else if (!ex)
        begin
            at_x = cx + 1'b1;
        end
        else
        begin
            at_x = '0;
            if (!ey)
            begin
                at_y = cy + 1'b1;
            end
            else
            begin
                at_y = '0;
                at_z = cz + 1'b1;
            end
        end
    endfunction

    function automatic logic [VOXEL_W-1:0] pick_voxel(input fill_t fill);
        case (fill)
            FILL_EMPTY:  return '0;
            FILL_SPARSE: return ($urandom_range(0, 9) == 0) ? VOXEL_W'($urandom_range(1, 255))
                                                            : '0;
            default:     return VOXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [BOUND_W-1:0] want,
                                          input logic [BOUND_W-1:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("Mismatch on %s of result %0d: expected %0d, got %0d",
                         name, results_seen, $signed(want), $signed(got));
        end
    endfunction

    // Leaves valid high after the transfer; a gap in the next call or settle() lowers it.
    task automatic send_voxel(input logic [VOXEL_W-1:0] v);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            voxel_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        voxel_valid <= 1'b1;
        voxel <= v;
        @(posedge clk);
        while (voxel_stall)
            @(posedge clk);
        track_voxel(v);
    endtask

    task automatic send_volume(input fill_t fill, input int count);
        for (int i = 0; i < count; i++)
            send_voxel(pick_voxel(fill));
    endtask

    // Callers lower cfg_valid once their batch of writes is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ORIGIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (idx)
            CFG_SIZE_X:   size_x_reg = data[SIZE_W-1:0];
            CFG_SIZE_Y:   size_y_reg = data[SIZE_W-1:0];
            CFG_SIZE_Z:   size_z_reg = data[SIZE_W-1:0];
            CFG_ORIGIN_X: org_x = data;
            CFG_ORIGIN_Y: org_y = data;
            CFG_ORIGIN_Z: org_z = data;
            default: ;
        endcase
    endtask

    // Waits until every expected box has been taken and the block has gone quiet.
    task automatic settle();
        voxel_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size writes carry random junk above the size field, which must be ignored.
    task automatic configure(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                             input logic [SIZE_W-1:0] sz, input logic [ORIGIN_W-1:0] ox,
                             input logic [ORIGIN_W-1:0] oy, input logic [ORIGIN_W-1:0] oz);
        settle();
        write_reg(CFG_SIZE_X, {(ORIGIN_W - SIZE_W)'($urandom), sx});
        write_reg(CFG_SIZE_Y, {(ORIGIN_W - SIZE_W)'($urandom), sy});
        write_reg(CFG_SIZE_Z, {(ORIGIN_W - SIZE_W)'($urandom), sz});
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setup();
        logic [SIZE_W-1:0]   s [3];
        logic [ORIGIN_W-1:0] o [3];
        for (int a = 0; a < 3; a++)
        begin
            s[a] = SIZE_W'($urandom_range(0, 4));
            case ($urandom_range(0, 5))
                0:       o[a] = 16'h7FFF;
                1:       o[a] = 16'h8000;
                default: o[a] = ORIGIN_W'($urandom);
            endcase
        end
        // Now and then one long axis, kept thin on the others so the volume stays short.
        if ($urandom_range(0, 15) == 0)
        begin
            s[0] = SIZE_W'(1);
            s[1] = SIZE_W'(1);
            s[2] = SIZE_W'(1);
            s[$urandom_range(0, 2)] = SIZE_W'($urandom_range(20, 80));
        end
        configure(s[0], s[1], s[2], o[0], o[1], o[2]);
    endtask

    task automatic run_volumes(input int budget, input bit with_hold);
        int start;
        start = voxel_count;
        while (voxel_count - start < budget)
        begin
            random_setup();
            if (with_hold && !hold_used && voxel_count - start > budget / 3)
            begin
                hold_request = HOLD_OFF_CYCLES;
                hold_used = 1'b1;
            end
            repeat ($urandom_range(1, 4))
                send_volume(fill_t'($urandom_range(0, 2)), volume_len());
            // Sometimes stop part-way so the next setup lands in the middle of a volume.
            if ($urandom_range(0, 7) == 0 && volume_len() > 1)
                send_volume(fill_t'($urandom_range(0, 2)), $urandom_range(1, volume_len() - 1));
        end
    endtask

    task automatic test_power_on_defaults();
        send_voxel(8'h00);
        send_voxel(8'hFF);
        send_voxel(8'h01);
        settle();
    endtask

    task automatic test_empty_and_wide_bounds();
        // Size zero on x acts as one; the y bound goes past the 16-bit range.
        configure(9'd0, 9'd2, 9'd1, 16'h8000, 16'h7FFF, 16'h1234);
        send_voxel(8'h00);
        send_voxel(8'h00);
        send_voxel(8'h00);
        send_voxel(8'h80);
        settle();
    endtask

    task automatic test_mid_volume_resize();
        configure(9'd3, 9'd3, 9'd1, ORIGIN_W'($urandom), ORIGIN_W'($urandom),
                  ORIGIN_W'($urandom));
        send_voxel(8'h00);
        send_voxel(8'h09);
        send_voxel(8'h00);
        send_voxel(8'h00);
        send_voxel(8'h03);
        settle();
        // The x counter now sits past the last column of the narrower volume.
        write_reg(CFG_SIZE_X, 16'd2);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h5A5A);
        cfg_valid <= 1'b0;
        send_voxel(8'hFF);
        send_voxel(8'h00);
        send_voxel(8'h40);
        settle();
    endtask

    task automatic test_extreme_sizes();
        configure(9'd256, 9'd1, 9'd1, 16'h7FFF, 16'h8000, 16'h0000);
        for (int i = 0; i < MAX_DIM; i++)
            send_voxel((i == 0 || i == MAX_DIM - 1) ? VOXEL_W'($urandom_range(1, 255))
                                                     : pick_voxel(FILL_SPARSE));
        configure(9'd1, 9'd511, 9'd1, 16'h0000, 16'hFFFF, 16'h8000);
        send_volume(FILL_SPARSE, volume_len());
        configure(9'd1, 9'd1, 9'd300, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_volume(FILL_DENSE, volume_len());
        settle();
    endtask

    // The sink holds off while short volumes keep coming, so the final voxel
    // of a later volume has to wait at the input.
    task automatic test_long_hold();
        configure(9'd2, 9'd1, 9'd1, ORIGIN_W'($urandom), ORIGIN_W'($urandom),
                  ORIGIN_W'($urandom));
        hold_request = HOLD_OFF_CYCLES;
        send_volume(FILL_DENSE, 8 * volume_len());
        settle();
    endtask

    task automatic test_random_volumes();
        run_volumes(RANDOM_ITEMS, 1'b1);
        settle();
    endtask

    task automatic test_quiet_tail();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        run_volumes(TAIL_ITEMS, 1'b0);
        settle();
    endtask

    // Result sink: random stall bursts, plus one long hold-off on request.
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                result_stall <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        box_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_boxes.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Result %0d transferred with no box expected", results_seen);
            end
            else
            begin
                want = pending_boxes.pop_front();
                compare_field("found", BOUND_W'(want.found), BOUND_W'(found));
                compare_field("min_x", want.min_x, min_x);
                compare_field("min_y", want.min_y, min_y);
                compare_field("min_z", want.min_z, min_z);
                compare_field("max_x", want.max_x, max_x);
                compare_field("max_y", want.max_y, max_y);
                compare_field("max_z", want.max_z, max_z);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("Timed out with %0d boxes outstanding", pending_boxes.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SIZE_X;
        cfg_data <= '0;
        voxel_valid <= 1'b0;
        voxel <= '0;
        size_x_reg = SIZE_W'(1);
        size_y_reg = SIZE_W'(1);
        size_z_reg = SIZE_W'(1);
        org_x = '0;
        org_y = '0;
        org_z = '0;
        clear_volume();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_empty_and_wide_bounds();
        test_mid_volume_resize();
        test_extreme_sizes();
        test_long_hold();
        test_random_volumes();
        test_quiet_tail();

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("Streamed %0d voxels in %0d volumes (%0d occupied) after %0d register writes.",
                 voxel_count, volume_count, occupied_volumes, reg_writes);
        $display("Sizes ran from one to the clamped maximum, with resizing mid-volume");
        $display("and a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        if (failures == 0 && pending_boxes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
